// ===== design/nlp_pkg.sv =====
`timescale 1ns / 1ps

package nlp_pkg;

    // Width of the packet size field and of the in-packet byte position.
    localparam int SIZE_BITS = 24;

    // Width of the sum that checks a NAL against the packet end.
    localparam int POS_W = SIZE_BITS + 1;
    localparam int SUM_W = ((POS_W > 32) ? POS_W : 32) + 1;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Length prefix size limits and reset value.
    localparam logic [2:0] LEN_BYTES_MIN   = 3'd1;
    localparam logic [2:0] LEN_BYTES_MAX   = 3'd4;
    localparam logic [2:0] LEN_BYTES_RESET = 3'd4;

    // Number of bytes in the start code.
    localparam logic [2:0] CODE_LEN = 3'd4;

    localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

    typedef struct packed {
        logic [7:0]           in_byte;
        logic [SIZE_BITS-1:0] packet_size;
        logic                 packet_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       packet_ok;
        logic       run_last;
    } out_item_t;

    // One command per input byte that produces output.
    typedef struct packed {
        logic       emit_code;
        logic       emit_byte;
        logic       emit_status;
        logic       packet_ok;
        logic [7:0] data_byte;
    } cmd_t;

endpackage

// ===== design/nlp_front.sv =====
`timescale 1ns / 1ps

module nlp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  nlp_pkg::in_item_t in_item,
    input  logic [2:0]        len_bytes,
    output logic              cmd_push,
    output nlp_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        PH_LEN,
        PH_PAYLOAD,
        PH_DROP
    } phase_t;

    phase_t                        phase_reg;
    logic [nlp_pkg::SIZE_BITS-1:0] offset_reg;
    logic [2:0]                    seen_reg;
    logic [31:0]                   accum_reg;
    logic [31:0]                   left_reg;
    logic                          emitted_reg;

    logic [2:0]                    lf;
    logic [2:0]                    seen_next;
    logic [31:0]                   accum_next;
    logic [31:0]                   left_next;
    logic [nlp_pkg::POS_W-1:0]     size_ext;
    logic [nlp_pkg::POS_W-1:0]     end_off;
    logic [nlp_pkg::POS_W-1:0]     limit;
    logic                          start_fits;
    logic                          field_done;
    logic                          nal_ok;
    logic                          emit_code;
    logic                          emit_byte;

    // Clamp the configured prefix size to 1..4.
    always_comb
    begin
        if (len_bytes < nlp_pkg::LEN_BYTES_MIN)
            lf = nlp_pkg::LEN_BYTES_MIN;
        else if (len_bytes > nlp_pkg::LEN_BYTES_MAX)
            lf = nlp_pkg::LEN_BYTES_MAX;
        else
            lf = len_bytes;
    end

    // Classify the current byte against the length field and the packet end.
    always_comb
    begin
        seen_next  = seen_reg + 3'd1;
        accum_next = {accum_reg[23:0], in_item.in_byte};
        left_next  = (left_reg != 32'd0) ? left_reg - 32'd1 : left_reg;
        size_ext   = {1'b0, in_item.packet_size};
        end_off    = {1'b0, offset_reg} + nlp_pkg::POS_W'(1);
        start_fits = ({1'b0, offset_reg} + nlp_pkg::POS_W'(lf)) <= size_ext;
        limit      = (in_item.packet_last && (end_off < size_ext)) ? end_off : size_ext;
        field_done = seen_next >= lf;
        nal_ok     = (accum_next != 32'd0) &&
                     ((nlp_pkg::SUM_W'(end_off) + nlp_pkg::SUM_W'(accum_next))
                      <= nlp_pkg::SUM_W'(limit));
        emit_code  = (phase_reg == PH_LEN) && !((seen_reg == 3'd0) && !start_fits) &&
                     field_done && nal_ok;
        emit_byte  = (phase_reg == PH_PAYLOAD);
    end

    // Command for the back part.
    always_comb
    begin
        cmd.emit_code   = emit_code;
        cmd.emit_byte   = emit_byte;
        cmd.emit_status = in_item.packet_last;
        cmd.packet_ok   = emitted_reg | emit_code;
        cmd.data_byte   = in_item.in_byte;
        cmd_push        = accept && (emit_code || emit_byte || in_item.packet_last);
    end

    // Per-packet parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEN;
            offset_reg  <= '0;
            seen_reg    <= 3'd0;
            accum_reg   <= 32'd0;
            left_reg    <= 32'd0;
            emitted_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (in_item.packet_last)
            begin
                phase_reg   <= PH_LEN;
                offset_reg  <= '0;
                seen_reg    <= 3'd0;
                accum_reg   <= 32'd0;
                left_reg    <= 32'd0;
                emitted_reg <= 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_LEN:
                    begin
                        if ((seen_reg == 3'd0) && !start_fits)
                            phase_reg <= PH_DROP;
                        else if (field_done)
                        begin
                            seen_reg  <= 3'd0;
                            accum_reg <= 32'd0;
                            if (nal_ok)
                            begin
                                phase_reg   <= PH_PAYLOAD;
                                left_reg    <= accum_next;
                                emitted_reg <= 1'b1;
                            end
                            else
                                phase_reg <= PH_DROP;
                        end
                        else
                        begin
                            seen_reg  <= seen_next;
                            accum_reg <= accum_next;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        left_reg <= left_next;
                        if (left_next == 32'd0)
                            phase_reg <= PH_LEN;
                    end
                    default:
                    begin
                        phase_reg <= PH_DROP;
                    end
                endcase
                if (offset_reg != '1)
                    offset_reg <= offset_reg + nlp_pkg::SIZE_BITS'(1);
            end
        end
    end

endmodule

// ===== design/nlp_queue.sv =====
`timescale 1ns / 1ps

module nlp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  nlp_pkg::cmd_t wr_cmd,
    input  logic          rd_en,
    output nlp_pkg::cmd_t rd_cmd,
    output logic          full,
    output logic          empty
);

    nlp_pkg::cmd_t                 slot_reg [nlp_pkg::QUEUE_DEPTH];
    logic [nlp_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [nlp_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [nlp_pkg::QUEUE_AW:0]    count_reg;

    assign full   = (count_reg == (nlp_pkg::QUEUE_AW + 1)'(nlp_pkg::QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = slot_reg[rd_ptr_reg];

    // Storage slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + nlp_pkg::QUEUE_AW'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + nlp_pkg::QUEUE_AW'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + (nlp_pkg::QUEUE_AW + 1)'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - (nlp_pkg::QUEUE_AW + 1)'(1);
        end
    end

endmodule

// ===== design/nlp_back.sv =====
`timescale 1ns / 1ps

module nlp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  nlp_pkg::cmd_t      cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output nlp_pkg::out_item_t out_item,
    output logic               empty,
    input  logic               pop
);

    logic [2:0]         step_reg;
    logic               out_valid_reg;
    nlp_pkg::out_item_t out_reg;

    logic [2:0]         count;
    logic [2:0]         last_step;
    logic               advance;
    nlp_pkg::out_item_t item;

    assign out_item = out_reg;
    assign empty    = !out_valid_reg;
    assign advance  = !out_valid_reg || pop;
    assign cmd_pop  = advance && !cmd_empty && (step_reg == last_step);

    // Number of words the head command expands into.
    always_comb
    begin
        count = (cmd.emit_code ? nlp_pkg::CODE_LEN : 3'd0) +
                (cmd.emit_byte ? 3'd1 : 3'd0) +
                (cmd.emit_status ? 3'd1 : 3'd0);
        last_step = count - 3'd1;
    end

    // Select the word for the current step: start code, payload byte or status.
    always_comb
    begin
        item.run_last = (step_reg == last_step);
        if (cmd.emit_code && (step_reg < nlp_pkg::CODE_LEN))
        begin
            item.out_byte  = nlp_pkg::START_CODE[step_reg[1:0]];
            item.is_status = 1'b0;
            item.packet_ok = 1'b0;
        end
        else if (cmd.emit_byte && (step_reg == 3'd0))
        begin
            item.out_byte  = cmd.data_byte;
            item.is_status = 1'b0;
            item.packet_ok = 1'b0;
        end
        else
        begin
            item.out_byte  = 8'h00;
            item.is_status = 1'b1;
            item.packet_ok = cmd.packet_ok;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (advance && !cmd_empty)
            out_reg <= item;
    end

    // Step counter and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= !cmd_empty;
            if (!cmd_empty)
            begin
                if (step_reg == last_step)
                    step_reg <= 3'd0;
                else
                    step_reg <= step_reg + 3'd1;
            end
        end
    end

endmodule

// ===== design/nal_length_prefix_to_start_code.sv =====
`timescale 1ns / 1ps

// Channel   | Signals                        | Accepted when
// ----------+--------------------------------+---------------------
// input     | push, full, in_item            | push && !full
// result    | pop, empty, out_item           | pop && !empty
// config    | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
// One input word is taken per cycle while the command queue has room.
// The result side delivers one word per cycle while pop is high; a
// completed length field costs four start code words, so the queue
// absorbs that burst. Result words are registered from queued commands.
// Reset clears all parse state and sets the prefix size to four bytes.
// A stalled result side fills the four-entry queue, then raises full.

module nal_length_prefix_to_start_code (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  nlp_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output nlp_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_data
);

    logic [2:0]    len_bytes_reg;
    logic          accept;
    logic          cmd_push;
    logic          cmd_pop;
    logic          q_full;
    logic          q_empty;
    nlp_pkg::cmd_t front_cmd;
    nlp_pkg::cmd_t head_cmd;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;

    // Length prefix size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_bytes_reg <= nlp_pkg::LEN_BYTES_RESET;
        else if (cfg_valid && cfg_ready)
            len_bytes_reg <= cfg_data;
    end

    nlp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_item   (in_item),
        .len_bytes (len_bytes_reg),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    nlp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (front_cmd),
        .rd_en  (cmd_pop),
        .rd_cmd (head_cmd),
        .full   (q_full),
        .empty  (q_empty)
    );

    nlp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (q_empty),
        .cmd_pop   (cmd_pop),
        .out_item  (out_item),
        .empty     (empty),
        .pop       (pop)
    );

    // A status word carries a zero byte and always ends its run.
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.is_status) |-> (out_item.out_byte == 8'h00 && out_item.run_last))
        else $error("status word malformed");

    // Data words never report packet_ok.
    a_data_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_item.is_status) |-> !out_item.packet_ok)
        else $error("data word with packet_ok set");

    // A command is taken from the queue only when one is present.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !q_empty)
        else $error("command queue underflow");

    // A held result word does not change while the result side stalls.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result word changed under stall");

endmodule
